### sv/bthome_object_parser_macros.svh
// assertion macros for the bthome object parser
`ifndef BTHOME_OBJECT_PARSER_MACROS_SVH
`define BTHOME_OBJECT_PARSER_MACROS_SVH

// property must hold at every clock edge out of reset
`define BOP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define BOP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### sv/bop_pkg.sv
// types and constants shared by the bthome object parser modules
package bop_pkg;

    localparam int OUT_W = 40;

    localparam logic [7:0] HDR_MASK  = 8'hE0;
    localparam logic [7:0] HDR_V2    = 8'h40;
    localparam logic [7:0] OBJ_PID   = 8'h00;
    localparam logic [7:0] OBJ_BAT   = 8'h01;
    localparam logic [7:0] OBJ_SKIP  = 8'h2C;
    localparam logic [7:0] OBJ_DIST  = 8'h40;
    localparam logic [1:0] CNT_SAT   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_HDR   = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_OBJID  = 7'b0000010,
        PH_PID    = 7'b0000100,
        PH_BAT    = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_DLO    = 7'b0100000,
        PH_DHI    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     frame_status;
        logic [7:0]  pkt_seq;
        logic [7:0]  battery_pct;
        logic        battery_seen;
        logic [15:0] range_mm;
        logic        distance_seen;
        logic        forward;
        logic        frame_done;
    } t_result;

endpackage

### sv/bop_in_reg.sv
// input register stage holding one accepted payload byte
module bop_in_reg
    import bop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### sv/bop_core.sv
// object walk state and per-byte result logic
module bop_core
    import bop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    output t_result  o_result
);

    t_phase      r_phase, n_phase, w_phase;
    logic [1:0]  r_count, n_count, w_count;
    logic        r_hdr_bad, n_hdr_bad, w_hdr_bad;
    logic        r_stopped, n_stopped, w_stopped;
    logic [7:0]  r_id, n_id, w_id;
    logic [7:0]  r_bat, n_bat, w_bat;
    logic        r_bat_seen, n_bat_seen, w_bat_seen;
    logic [15:0] r_dist, n_dist, w_dist;
    logic [7:0]  r_dist_lo, n_dist_lo, w_dist_lo;
    logic        r_dist_seen, n_dist_seen, w_dist_seen;
    logic        r_fwd_none, n_fwd_none;
    logic [7:0]  r_fwd_id, n_fwd_id;
    t_status     w_status;
    logic        w_fwd;
    logic [7:0]  b;

    assign b = i_item.data_byte;

    // state after taking the byte
    always_comb begin
        w_phase     = r_phase;
        w_count     = (r_count == CNT_SAT) ? CNT_SAT : r_count + 2'd1;
        w_hdr_bad   = r_hdr_bad;
        w_stopped   = r_stopped;
        w_id        = r_id;
        w_bat       = r_bat;
        w_bat_seen  = r_bat_seen;
        w_dist      = r_dist;
        w_dist_lo   = r_dist_lo;
        w_dist_seen = r_dist_seen;
        if (r_phase == PH_HEADER) begin
            w_hdr_bad = ((b & HDR_MASK) != HDR_V2);
            w_phase   = PH_OBJID;
        end else if (!r_hdr_bad && !r_stopped) begin
            unique case (r_phase)
                PH_OBJID: begin
                    if (b == OBJ_PID) begin
                        w_phase = PH_PID;
                    end else if (b == OBJ_BAT) begin
                        w_phase = PH_BAT;
                    end else if (b == OBJ_SKIP) begin
                        w_phase = PH_SKIP;
                    end else if (b == OBJ_DIST) begin
                        w_phase = PH_DLO;
                    end else begin
                        w_stopped = 1'b1;
                    end
                end
                PH_PID: begin
                    w_id    = b;
                    w_phase = PH_OBJID;
                end
                PH_BAT: begin
                    w_bat      = b;
                    w_bat_seen = 1'b1;
                    w_phase    = PH_OBJID;
                end
                PH_DLO: begin
                    w_dist_lo = b;
                    w_phase   = PH_DHI;
                end
                PH_DHI: begin
                    w_dist      = {b, r_dist_lo};
                    w_dist_seen = 1'b1;
                    w_phase     = PH_OBJID;
                end
                default: begin
                    w_phase = PH_OBJID;
                end
            endcase
        end
    end

    // frame report on the last byte
    always_comb begin
        if (w_count != CNT_SAT) begin
            w_status = ST_SHORT;
        end else if (w_hdr_bad) begin
            w_status = ST_BAD_HDR;
        end else if (!w_stopped && w_phase != PH_OBJID) begin
            w_status = ST_TRUNCATED;
        end else begin
            w_status = ST_OK;
        end
        w_fwd = (w_status == ST_OK) && w_bat_seen && w_dist_seen &&
                (r_fwd_none || (w_id != r_fwd_id));

        o_result = '0;
        if (i_item.last_byte) begin
            o_result.frame_status = w_status;
            o_result.frame_done   = 1'b1;
            if (w_status == ST_OK) begin
                o_result.pkt_seq       = w_id;
                o_result.battery_pct   = w_bat;
                o_result.battery_seen  = w_bat_seen;
                o_result.range_mm      = w_dist;
                o_result.distance_seen = w_dist_seen;
                o_result.forward       = w_fwd;
            end
        end
    end

    always_comb begin
        n_fwd_none = r_fwd_none;
        n_fwd_id   = r_fwd_id;
        if (i_item.last_byte) begin
            n_phase     = PH_HEADER;
            n_count     = '0;
            n_hdr_bad   = 1'b0;
            n_stopped   = 1'b0;
            n_id        = '0;
            n_bat       = '0;
            n_bat_seen  = 1'b0;
            n_dist      = '0;
            n_dist_lo   = '0;
            n_dist_seen = 1'b0;
            if (w_fwd) begin
                n_fwd_none = 1'b0;
                n_fwd_id   = w_id;
            end
        end else begin
            n_phase     = w_phase;
            n_count     = w_count;
            n_hdr_bad   = w_hdr_bad;
            n_stopped   = w_stopped;
            n_id        = w_id;
            n_bat       = w_bat;
            n_bat_seen  = w_bat_seen;
            n_dist      = w_dist;
            n_dist_lo   = w_dist_lo;
            n_dist_seen = w_dist_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_hdr_bad   <= 1'b0;
            r_stopped   <= 1'b0;
            r_id        <= '0;
            r_bat       <= '0;
            r_bat_seen  <= 1'b0;
            r_dist      <= '0;
            r_dist_lo   <= '0;
            r_dist_seen <= 1'b0;
            r_fwd_none  <= 1'b1;
            r_fwd_id    <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_hdr_bad   <= n_hdr_bad;
            r_stopped   <= n_stopped;
            r_id        <= n_id;
            r_bat       <= n_bat;
            r_bat_seen  <= n_bat_seen;
            r_dist      <= n_dist;
            r_dist_lo   <= n_dist_lo;
            r_dist_seen <= n_dist_seen;
            r_fwd_none  <= n_fwd_none;
            r_fwd_id    <= n_fwd_id;
        end
    end

endmodule

### sv/bthome_object_parser.sv
// bthome v2 service-data object parser, top level with result register
// an accepted byte passes from the input register through the combinational core into the result register
// throughput: one byte per cycle while the output is not stalled, set by the parser state update
// each byte gives exactly one result transaction; only the last one carries tlast
// reset (synchronous, active low) empties both registers and clears the frame state
// the last forwarded packet id is cleared by reset only
`include "bthome_object_parser_macros.svh"

module bthome_object_parser
    import bop_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // data_byte
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // frame_status[1:0], pkt_seq[9:2], battery_pct[17:10], battery_seen[18],
    // range_mm[34:19], distance_seen[35], forward[36], zero fill[39:37]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    t_in_item w_in_item;
    t_in_item w_reg_item;
    logic     w_reg_valid;
    logic     w_advance;
    t_result  w_result;
    t_result  r_out;
    logic     r_out_valid;
    logic     w_out_fwd;
    logic     w_fwd_legal;
    logic     w_mid_dirty;
    logic     w_fail_dirty;

    assign w_in_item.data_byte = s_axis_tdata;
    assign w_in_item.last_byte = s_axis_tlast;
    assign w_advance = w_reg_valid && (!r_out_valid || m_axis_tready);

    bop_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_reg_valid),
        .o_item    (w_reg_item)
    );

    bop_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_reg_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.frame_done;
    assign m_axis_tdata  = {3'b000, r_out.forward, r_out.distance_seen, r_out.range_mm,
                            r_out.battery_seen, r_out.battery_pct, r_out.pkt_seq,
                            r_out.frame_status};

    assign w_out_fwd    = r_out_valid && r_out.forward;
    assign w_fwd_legal  = r_out.frame_done && r_out.frame_status == ST_OK &&
                          r_out.battery_seen && r_out.distance_seen;
    assign w_mid_dirty  = r_out_valid && !r_out.frame_done &&
                          (r_out.frame_status != ST_OK || r_out.pkt_seq != 8'h00 ||
                           r_out.battery_seen || r_out.distance_seen);
    assign w_fail_dirty = r_out_valid && r_out.frame_status != ST_OK &&
                          (r_out.pkt_seq != 8'h00 || r_out.range_mm != 16'h0000 ||
                           r_out.battery_pct != 8'h00);

    `BOP_ASSERT(a_fwd_only_ok, w_out_fwd |-> w_fwd_legal, "forward without a complete ok frame")
    `BOP_NEVER(a_mid_zero, w_mid_dirty, "nonzero result before the last byte")
    `BOP_NEVER(a_bad_fields, w_fail_dirty, "decoded fields on a failed frame")

endmodule
